// ===== sv/trd_pkg.sv =====
// Shared constants, types and word assembly for the tracker record deframer.
package trd_pkg;

    localparam int unsigned RecordLen = 12;
    localparam int unsigned WordCount = 6;
    localparam int unsigned DataBits  = 7;
    localparam int unsigned IndexBits = 4;
    localparam int unsigned HeldDepth = RecordLen - 1;

    typedef logic [IndexBits-1:0] t_index;
    typedef logic [DataBits-1:0]  t_data;
    typedef logic signed [15:0]   t_word;

    localparam t_index IdxHunt = t_index'(0);
    localparam t_index IdxLast = t_index'(RecordLen - 1);
    localparam t_index IdxEnd  = t_index'(RecordLen);

    // Word from a byte pair: high data bits at 15:9, low data bits at 8:2.
    function automatic t_word make_word(input t_data low, input t_data high);
        make_word = {high, low, 2'b00};
    endfunction

endpackage

// ===== sv/tracker_record_deframer_unit.sv =====
// Top level of the tracker record deframer: byte intake, record capture, word output.
//
// Usage: bytes from a serial receiver enter on i_valid / o_stall / i_rx_byte,
// one request per clock at most. While hunting, bytes without bit 7 set are
// dropped. A byte with bit 7 set opens a 12-byte record; the next 11 bytes are
// data whatever their bit 7. The twelfth byte produces one result request on
// o_valid / i_stall carrying six signed 16-bit words (X, Y, Z position and
// Z, Y, X rotation), each built from the low 7 bits of a byte pair.
// The twelfth byte is taken into the input register; the words then load the
// result register when it can advance (no result waiting under i_stall).
// Throughput: one byte per cycle while no stall holds the flow, set by the
// combinational decode between the two registers.
// Stall: while a result waits under i_stall, one more byte can still be
// taken into the input register; o_stall rises only when both registers are
// full and the result is not taken. Payload holds while stalled.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// deframer to hunting. Held record bytes are not cleared; they are always
// rewritten before use.
module tracker_record_deframer_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [15:0]   o_pos_x,
    output logic signed [15:0]   o_pos_y,
    output logic signed [15:0]   o_pos_z,
    output logic signed [15:0]   o_rot_z,
    output logic signed [15:0]   o_rot_y,
    output logic signed [15:0]   o_rot_x
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    trd_pkg::t_index       r_byte_index;
    trd_pkg::t_index       n_byte_index;
    trd_pkg::t_data        r_held [trd_pkg::HeldDepth];
    logic                  r_out_valid;
    trd_pkg::t_word        r_words [trd_pkg::WordCount];
    trd_pkg::t_data        rec [trd_pkg::RecordLen];
    logic                  advance;
    logic                  hunting;
    logic                  complete;
    logic                  write_held;

    assign advance  = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !advance;
    assign hunting  = (r_byte_index == trd_pkg::IdxHunt) || (r_byte_index >= trd_pkg::IdxEnd);
    assign complete = r_in_valid && !hunting && (r_byte_index == trd_pkg::IdxLast);

    always_comb begin
        n_byte_index = r_byte_index;
        write_held   = 1'b0;
        if (hunting) begin
            if (r_in_byte[7]) begin
                n_byte_index = trd_pkg::t_index'(1);
                write_held   = 1'b1;
            end else begin
                n_byte_index = trd_pkg::IdxHunt;
            end
        end else if (r_byte_index == trd_pkg::IdxLast) begin
            n_byte_index = trd_pkg::IdxHunt;
        end else begin
            n_byte_index = r_byte_index + trd_pkg::t_index'(1);
            write_held   = 1'b1;
        end
    end

    // Record view: held bytes plus the closing byte in the last slot.
    always_comb begin
        for (int k = 0; k < trd_pkg::HeldDepth; k++) begin
            rec[k] = r_held[k];
        end
        rec[trd_pkg::HeldDepth] = r_in_byte[trd_pkg::DataBits-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= trd_pkg::IdxHunt;
            r_out_valid  <= 1'b0;
        end else if (advance) begin
            r_out_valid <= complete;
            if (r_in_valid) begin
                r_byte_index <= n_byte_index;
            end
        end
    end

    // Hunting resets the slot to zero, so the write address is the old index.
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && write_held) begin
            if (hunting) begin
                r_held[0] <= r_in_byte[trd_pkg::DataBits-1:0];
            end else begin
                r_held[r_byte_index] <= r_in_byte[trd_pkg::DataBits-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && complete) begin
            for (int k = 0; k < trd_pkg::WordCount; k++) begin
                r_words[k] <= trd_pkg::make_word(rec[2*k], rec[2*k+1]);
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_pos_x = r_words[0];
    assign o_pos_y = r_words[1];
    assign o_pos_z = r_words[2];
    assign o_rot_z = r_words[3];
    assign o_rot_y = r_words[4];
    assign o_rot_x = r_words[5];

endmodule

// ===== tb/sv/tb_tracker_record_deframer_unit.sv =====
// Self-checking testbench for the tracker record deframer: byte stream in, pose words checked.
module tb_tracker_record_deframer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QuietLimit    = 2000;
    localparam int unsigned SettleCycles  = 8;
    localparam int unsigned RandomRecords = 52;
    localparam int unsigned LongHold      = 300;

    typedef struct packed {
        trd_pkg::t_word pos_x;
        trd_pkg::t_word pos_y;
        trd_pkg::t_word pos_z;
        trd_pkg::t_word rot_z;
        trd_pkg::t_word rot_y;
        trd_pkg::t_word rot_x;
    } t_pose;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_pos_x;
    logic signed [15:0] o_pos_y;
    logic signed [15:0] o_pos_z;
    logic signed [15:0] o_rot_z;
    logic signed [15:0] o_rot_y;
    logic signed [15:0] o_rot_x;

    // Shadow of the deframer state
    trd_pkg::t_index record_index = trd_pkg::IdxHunt;
    trd_pkg::t_data  record_bytes [trd_pkg::HeldDepth];
    t_pose           expected_poses [$];

    int unsigned mismatch_count = 0;
    bit          steady_flow = 1'b0;
    int unsigned hold_off = 0;

    tracker_record_deframer_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_pos_x   (o_pos_x),
        .o_pos_y   (o_pos_y),
        .o_pos_z   (o_pos_z),
        .o_rot_z   (o_rot_z),
        .o_rot_y   (o_rot_y),
        .o_rot_x   (o_rot_x)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic trd_pkg::t_word pair_word(trd_pkg::t_data lo, trd_pkg::t_data hi);
        return trd_pkg::t_word'((int'(hi) << 9) | (int'(lo) << 2));
    endfunction

    // Advance the shadow deframer by one byte; queue a pose when a record closes.
    function automatic void deframe_byte(logic [7:0] b);
        trd_pkg::t_data rec [trd_pkg::RecordLen];
        t_pose pose;
        if (record_index == trd_pkg::IdxHunt || record_index >= trd_pkg::IdxEnd) begin
            if (b[7]) begin
                record_bytes[0] = b[6:0];
                record_index = trd_pkg::t_index'(1);
            end else begin
                record_index = trd_pkg::IdxHunt;
            end
        end else if (record_index < trd_pkg::IdxLast) begin
            record_bytes[record_index] = b[6:0];
            record_index = record_index + trd_pkg::t_index'(1);
        end else begin
            for (int i = 0; i < trd_pkg::HeldDepth; i++) rec[i] = record_bytes[i];
            rec[trd_pkg::RecordLen-1] = b[6:0];
            pose.pos_x = pair_word(rec[0], rec[1]);
            pose.pos_y = pair_word(rec[2], rec[3]);
            pose.pos_z = pair_word(rec[4], rec[5]);
            pose.rot_z = pair_word(rec[6], rec[7]);
            pose.rot_y = pair_word(rec[8], rec[9]);
            pose.rot_x = pair_word(rec[10], rec[11]);
            expected_poses.push_back(pose);
            record_index = trd_pkg::IdxHunt;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        deframe_byte(b);
        @(negedge i_clk);
    endtask

    task automatic send_record();
        send_byte(8'($urandom_range(128, 255)));
        repeat (trd_pkg::RecordLen - 1) send_byte(8'($urandom));
    endtask

    // Hold the sender until every queued pose has been taken, then let the block settle.
    task automatic drain_poses();
        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic check_word(input string name, input trd_pkg::t_word want,
                              input trd_pkg::t_word got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Dropped hunt bytes, an all-zero record, then a record of extreme words
    // with bit 7 set on data bytes.
    task automatic test_directed();
        logic [7:0] script [0:26] = '{
            8'h00, 8'h7F, 8'h2A,
            8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'h3F, 8'h00, 8'hC0, 8'hFF, 8'hFF,
            8'h80, 8'h80, 8'hAA, 8'h55, 8'h55, 8'hAA
        };
        foreach (script[i]) send_byte(script[i]);
        drain_poses();
    endtask

    // Mostly aligned records; some hunt noise and some bursts that break alignment.
    task automatic test_random_records();
        for (int n = 0; n < RandomRecords; n++) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 127)));
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 11)) send_byte(8'($urandom));
            send_record();
        end
        drain_poses();
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        repeat (6) send_record();
        steady_flow = 1'b0;
        drain_poses();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering bytes.
    task automatic test_backpressure();
        hold_off = LongHold;
        repeat (4) send_record();
        drain_poses();
    endtask

    initial begin : result_stall
        forever begin
            @(negedge i_clk);
            if (hold_off != 0) begin
                i_stall <= 1'b1;
                repeat (hold_off) @(negedge i_clk);
                hold_off = 0;
                i_stall <= 1'b0;
            end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat (pick_gap() + 1) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin : result_check
        t_pose want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_poses.size() == 0) begin
                    $error("unexpected result request: pos_x %0d", o_pos_x);
                    mismatch_count++;
                end else begin
                    want = expected_poses.pop_front();
                    check_word("pos_x", want.pos_x, o_pos_x);
                    check_word("pos_y", want.pos_y, o_pos_y);
                    check_word("pos_z", want.pos_z, o_pos_z);
                    check_word("rot_z", want.rot_z, o_rot_z);
                    check_word("rot_y", want.rot_y, o_rot_y);
                    check_word("rot_x", want.rot_x, o_rot_x);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
                if (quiet >= QuietLimit) begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_records();
        test_steady_stream();
        test_backpressure();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
